>>> design/qdd_pkg.sv
// ---------------------------------------------------------------------------
// qdd_pkg
// Types, register codes and lookup functions shared by the quadrature
// detent decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package qdd_pkg;

  localparam int NUM_ACTION_REGS = 3;
  localparam int APB_ADDR_W      = 4;
  localparam int APB_DATA_W      = 32;

  localparam logic [15:0] LOCKOUT_RESET = 16'd500;

  typedef enum logic [1:0] {
    ACT_VSCROLL = 2'd0,
    ACT_VOLUME  = 2'd1,
    ACT_HSCROLL = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_LOCKOUT = 2'd0,
    REG_ACTION0 = 2'd1,
    REG_ACTION1 = 2'd2,
    REG_ACTION2 = 2'd3
  } reg_idx_t;

  typedef logic [NUM_ACTION_REGS-1:0][1:0] action_regs_t;

  typedef struct packed {
    logic [15:0]  lockout_us;
    action_regs_t action;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  enc_index;
    logic        level_a;
    logic        level_b;
    logic        lock_group;
    logic        new_event;
    logic [31:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_encoder;
    logic       direction_up;
    logic [1:0] action;
  } out_item_t;

  // Quadrature step for the index {previous AB, new AB}.
  function automatic logic signed [1:0] step_of(logic [3:0] idx);
    logic signed [1:0] s;
    unique case (idx) inside
      4'd1, 4'd7, 4'd8, 4'd14:  s = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = -2'sd1;
      default:                  s = 2'sd0;
    endcase
    return s;
  endfunction

  // Action of an encoder; encoders without a register and unused codes
  // fall back to vertical scroll.
  function automatic logic [1:0] action_of(action_regs_t regs, logic [1:0] enc);
    logic [1:0] a;
    a = (32'(enc) >= NUM_ACTION_REGS) ? ACT_VSCROLL : regs[enc];
    return (a > ACT_HSCROLL) ? ACT_VSCROLL : a;
  endfunction

endpackage

`default_nettype wire

>>> design/qdd_stream_if.sv
// ---------------------------------------------------------------------------
// qdd_stream_if
// Valid/ready channel carrying one payload item per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface qdd_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/quadrature_detent_decoder.sv
// ---------------------------------------------------------------------------
// quadrature_detent_decoder
// Detent decoder for several quadrature encoders with group lockout.
// ---------------------------------------------------------------------------
// The sample register takes a beat and the result register then loads its
// detent result once the output is free. Throughput: one sample per cycle
// unless out_ch stalls; the stages are separate, so a stall holds only the sample.
// Per-sample work is one 32-bit elapsed-time compare plus a 16-entry step lookup.
// Reset (rst, synchronous): empties both stages, sets every encoder's AB to 3
// and its count to 0, clears group times and verdicts, restores registers.
`default_nettype none

module quadrature_detent_decoder #(
  parameter int NUM_ENC    = 3,
  parameter int NUM_GROUPS = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [qdd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [qdd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [qdd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  qdd_stream_if.sink                          in_ch,
  qdd_stream_if.source                        out_ch
);

  qdd_pkg::cfg_t      cfg;
  qdd_pkg::in_item_t  s1_data;
  logic               s1_valid;
  logic               out_free;
  logic               fire;
  logic               pass;
  logic               res_valid;
  qdd_pkg::out_item_t res;
  qdd_pkg::out_item_t out_data;
  logic               out_valid;

  qdd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free    = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || out_free;
  assign fire        = s1_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data <= in_ch.data;
    end
  end

  qdd_lockout #(
    .NUM_GROUPS (NUM_GROUPS)
  ) u_lockout (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .lock_group (s1_data.lock_group),
    .new_event  (s1_data.new_event),
    .now_us     (s1_data.now_us),
    .lockout_us (cfg.lockout_us),
    .pass       (pass)
  );

  qdd_detent #(
    .NUM_ENC (NUM_ENC)
  ) u_detent (
    .clk       (clk),
    .rst       (rst),
    .pass      (pass),
    .enc_index (s1_data.enc_index),
    .level_a   (s1_data.level_a),
    .level_b   (s1_data.level_b),
    .actions   (cfg.action),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= res;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  a_take_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ch.ready)
    else $error("sample stage empty but input not ready");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_data))
    else $error("pending sample lost while result stalled");

  a_result_needs_fire: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> fire)
    else $error("detent result without a processed sample");

  a_encoder_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_data.out_encoder) < 32'(NUM_ENC)))
    else $error("result names a nonexistent encoder");

  a_action_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.action == qdd_pkg::ACT_VSCROLL ||
                   out_data.action == qdd_pkg::ACT_VOLUME ||
                   out_data.action == qdd_pkg::ACT_HSCROLL))
    else $error("result carries an undefined action code");

endmodule

`default_nettype wire

>>> design/qdd_apb_regs.sv
// ---------------------------------------------------------------------------
// qdd_apb_regs
// APB register file: lockout time and the per-encoder action codes.
// ---------------------------------------------------------------------------
`default_nettype none

module qdd_apb_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [qdd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [qdd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [qdd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  output qdd_pkg::cfg_t                       cfg
);

  qdd_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = qdd_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lockout_us <= qdd_pkg::LOCKOUT_RESET;
      cfg.action[0]  <= qdd_pkg::ACT_VSCROLL;
      cfg.action[1]  <= qdd_pkg::ACT_VOLUME;
      cfg.action[2]  <= qdd_pkg::ACT_HSCROLL;
    end else if (wr_en) begin
      unique case (reg_idx)
        qdd_pkg::REG_LOCKOUT: cfg.lockout_us <= pwdata[15:0];
        qdd_pkg::REG_ACTION0: cfg.action[0]  <= pwdata[1:0];
        qdd_pkg::REG_ACTION1: cfg.action[1]  <= pwdata[1:0];
        qdd_pkg::REG_ACTION2: cfg.action[2]  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      qdd_pkg::REG_LOCKOUT: prdata = {16'd0, cfg.lockout_us};
      qdd_pkg::REG_ACTION0: prdata = {30'd0, cfg.action[0]};
      qdd_pkg::REG_ACTION1: prdata = {30'd0, cfg.action[1]};
      qdd_pkg::REG_ACTION2: prdata = {30'd0, cfg.action[2]};
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/qdd_lockout.sv
// ---------------------------------------------------------------------------
// qdd_lockout
// Per-group event lockout: decides whether a sample is passed on to the
// encoders and keeps each group's last accepted time and verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module qdd_lockout #(
  parameter int NUM_GROUPS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire logic        lock_group,
  input  wire logic        new_event,
  input  wire logic [31:0] now_us,
  input  wire logic [15:0] lockout_us,
  output logic             pass
);

  logic [31:0]           last_time [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] accepted;
  logic [NUM_GROUPS-1:0] hit;
  logic [31:0]           sel_time;
  logic                  sel_acc;
  logic                  grp_ok;
  logic [31:0]           elapsed;
  logic                  late;

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_hit
    assign hit[g] = (32'(lock_group) == 32'(g));
  end

  always_comb begin
    sel_time = '0;
    sel_acc  = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (hit[g]) begin
        sel_time = sel_time | last_time[g];
        sel_acc  = sel_acc | accepted[g];
      end
    end
  end

  // Samples naming a group that does not exist are dropped untouched.
  assign grp_ok  = |hit;
  assign elapsed = now_us - sel_time;
  assign late    = (elapsed >= {16'd0, lockout_us});
  assign pass    = fire && grp_ok && (new_event ? late : sel_acc);

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_state
    always_ff @(posedge clk) begin
      if (rst) begin
        last_time[g] <= '0;
        accepted[g]  <= 1'b0;
      end else if (fire && hit[g] && new_event) begin
        accepted[g] <= late;
        if (late) begin
          last_time[g] <= now_us;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/qdd_detent.sv
// ---------------------------------------------------------------------------
// qdd_detent
// Per-encoder quadrature state: step lookup, detent counting and the
// detent result for one passed sample.
// ---------------------------------------------------------------------------
`default_nettype none

module qdd_detent #(
  parameter int NUM_ENC = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pass,
  input  wire logic [1:0]            enc_index,
  input  wire logic                  level_a,
  input  wire logic                  level_b,
  input  wire qdd_pkg::action_regs_t actions,
  output logic                       res_valid,
  output qdd_pkg::out_item_t         res
);

  logic [1:0]        prev_ab [NUM_ENC];
  logic signed [1:0] count   [NUM_ENC];
  logic [NUM_ENC-1:0] hit;
  logic [1:0]        sel_prev;
  logic [1:0]        sel_count;
  logic signed [1:0] step;
  logic signed [2:0] sum;
  logic              up;
  logic              down;
  logic signed [1:0] count_next;

  for (genvar e = 0; e < NUM_ENC; e++) begin : g_hit
    assign hit[e] = (32'(enc_index) == 32'(e));
  end

  always_comb begin
    sel_prev  = '0;
    sel_count = '0;
    for (int e = 0; e < NUM_ENC; e++) begin
      if (hit[e]) begin
        sel_prev  = sel_prev | prev_ab[e];
        sel_count = sel_count | count[e];
      end
    end
  end

  assign step = qdd_pkg::step_of({sel_prev, level_a, level_b});
  assign sum  = {sel_count[1], sel_count} + {step[1], step};
  assign up   = (sum == 3'sd2);
  assign down = (sum == -3'sd2);
  // A full detent leaves the count at zero; otherwise it keeps the sum.
  assign count_next = (up || down) ? 2'sd0 : sum[1:0];

  assign res_valid        = pass && (|hit) && (up || down);
  assign res.out_encoder  = enc_index;
  assign res.direction_up = up;
  assign res.action       = qdd_pkg::action_of(actions, enc_index);

  for (genvar e = 0; e < NUM_ENC; e++) begin : g_state
    always_ff @(posedge clk) begin
      if (rst) begin
        prev_ab[e] <= 2'b11;
        count[e]   <= 2'sd0;
      end else if (pass && hit[e]) begin
        prev_ab[e] <= {level_a, level_b};
        count[e]   <= count_next;
      end
    end
  end

endmodule

`default_nettype wire
